/* sv/slbp_pkg.sv */
// Shared types and codes for the scope link byte parser.
package slbp_pkg;

  localparam int COL_W  = 10;
  localparam int ROW_W  = 8;
  localparam int WORD_W = 32;

  localparam logic [7:0] CMD_TIME  = 8'hFF;
  localparam logic [7:0] CMD_VOLTS = 8'hFE;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic CFG_FLIP_BASE   = 1'b0;
  localparam logic CFG_LAST_COLUMN = 1'b1;

  localparam logic [COL_W-1:0] FIRST_COLUMN = COL_W'(1);

  typedef struct packed {
    logic [ROW_W-1:0] flip_base;
    logic [COL_W-1:0] last_column;
  } cfg_t;

  typedef struct packed {
    logic              sample_valid;
    logic [COL_W-1:0]  sample_column;
    logic [ROW_W-1:0]  sample_row;
    logic              frame_ready;
    logic              time_div_valid;
    logic [WORD_W-1:0] time_div_value;
    logic              volts_div_valid;
    logic [WORD_W-1:0] volts_div_value;
  } res_t;

endpackage

/* sv/slbp_core.sv */
// Parser state and the per-byte update: modes, word assembly, column tracking.
module slbp_core import slbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  typedef enum logic [1:0] {
    MODE_DATA  = 2'd0,
    MODE_TIME  = 2'd1,
    MODE_VOLTS = 2'd2
  } mode_t;

  mode_t             parse_mode, parse_mode_next;
  logic [1:0]        byte_position, byte_position_next;
  logic [COL_W-1:0]  write_column, write_column_next;
  logic              frame_full, frame_full_next;
  logic [WORD_W-1:0] time_word, time_word_next;
  logic [WORD_W-1:0] volts_word, volts_word_next;
  logic [ROW_W-1:0]  row;
  logic [4:0]        lane;

  assign lane = {byte_position, 3'b000};

  always_comb begin
    parse_mode_next    = parse_mode;
    byte_position_next = byte_position;
    write_column_next  = write_column;
    frame_full_next    = frame_full;
    time_word_next     = time_word;
    volts_word_next    = volts_word;
    res                = '0;
    row                = cfg.flip_base - rx_byte;
    if (row == ROW_W'(1)) begin
      row = ROW_W'(2);
    end

    if (operation == OP_RELEASE) begin
      frame_full_next = 1'b0;
    end else if (parse_mode == MODE_TIME || parse_mode == MODE_VOLTS) begin
      if (parse_mode == MODE_TIME) begin
        time_word_next[lane +: 8] = rx_byte;
      end else begin
        volts_word_next[lane +: 8] = rx_byte;
      end
      byte_position_next = byte_position + 2'd1;
      if (byte_position == 2'd3) begin
        res.time_div_valid  = (parse_mode == MODE_TIME);
        res.volts_div_valid = (parse_mode == MODE_VOLTS);
        parse_mode_next     = MODE_DATA;
      end
    end else if (rx_byte == CMD_TIME) begin
      parse_mode_next = MODE_TIME;
    end else if (rx_byte == CMD_VOLTS) begin
      parse_mode_next = MODE_VOLTS;
    end else if (!frame_full) begin
      if (write_column == cfg.last_column) begin
        write_column_next = FIRST_COLUMN;
        frame_full_next   = 1'b1;
      end else begin
        write_column_next = write_column + COL_W'(1);
        res.sample_valid  = 1'b1;
        res.sample_column = write_column_next;
        res.sample_row    = row;
      end
    end

    res.frame_ready     = frame_full_next;
    res.time_div_value  = time_word_next;
    res.volts_div_value = volts_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= MODE_DATA;
      byte_position <= 2'd0;
      write_column  <= FIRST_COLUMN;
      frame_full    <= 1'b0;
      time_word     <= '0;
      volts_word    <= '0;
    end else if (take) begin
      parse_mode    <= parse_mode_next;
      byte_position <= byte_position_next;
      write_column  <= write_column_next;
      frame_full    <= frame_full_next;
      time_word     <= time_word_next;
      volts_word    <= volts_word_next;
    end
  end

  // a word is only ever in flight in a word mode
  assert property (@(posedge clk) disable iff (rst)
    parse_mode == MODE_DATA |-> byte_position == 2'd0)
    else $error("byte_position nonzero in data mode");

endmodule

/* sv/scope_link_byte_parser.sv */
// Top level of the scope link byte parser: config registers, handshake, result register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | tdata rx_byte, tuser operation
//  m_*     | out | m_tvalid / m_tready    | tdata column,row,frame,time,volts words
//  cfg_*   | in  | cfg_we (no back-press) | cfg_index, cfg_data
//
// One request per cycle while s_tready is high, one result per request; m_tvalid
// rises in the cycle after acceptance, set by the single result register.
// The request is decoded and the parser state updated in the accepting cycle.
// s_tready drops only while a result sits in the output register and m_tready is low.
// rst (synchronous) restores the config defaults and the parser state and
// empties the output register.
module scope_link_byte_parser import slbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [9:0] sample_column, [17:10] sample_row,
                                 // [18] frame_ready, [50:19] time_div_value,
                                 // [82:51] volts_div_value, [87:83] zero
  output logic [2:0]  m_tuser,   // [0] sample_valid, [1] time_div_valid,
                                 // [2] volts_div_valid
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  cfg_t cfg;
  res_t res, res_q;
  logic take;

  // output register frees up whenever the downstream side takes its content
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flip_base   <= ROW_W'(226);
      cfg.last_column <= COL_W'(319);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLIP_BASE:   cfg.flip_base   <= cfg_data[ROW_W-1:0];
        CFG_LAST_COLUMN: cfg.last_column <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  slbp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (s_tuser),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res       (res)
  );

  // result register; payload loads with each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
    if (take) begin
      res_q <= res;
    end
  end

  assign m_tdata = {5'b0, res_q.volts_div_value, res_q.time_div_value, res_q.frame_ready,
                    res_q.sample_row, res_q.sample_column};
  assign m_tuser = {res_q.volts_div_valid, res_q.time_div_valid, res_q.sample_valid};

  // a result strobes at most one kind of event
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("more than one event strobe in one result");

  // samples are only written while no frame is pending
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[18])
    else $error("sample written with frame ready");

  // row 1 is never produced
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[17:10] != 8'd1)
    else $error("sample row of one");

  // a request accepted with the result register empty shows up next cycle
  assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("accepted request produced no result");

endmodule
